// ----- design/bcl_pkg.sv -----
// Shared constants, types and helpers of the 3x3 binary closing block.
package bcl_pkg;

  // Line store depth: widest frame row supported
  localparam int MAX_WIDTH = 1024;

  // Derived widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int WARM_W = $clog2(2 * MAX_WIDTH + 3);

  // Register and field widths
  localparam int FW_W      = 11;
  localparam int FH_W      = 12;
  localparam int ROW_W     = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int LS_W      = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Register reset values
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Which neighbors of a window center lie inside the frame
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } bcl_edge_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic             dil_v;
    bcl_edge_t        dil_edge;
    logic [COL_W-1:0] dil_addr;
    logic             out_v;
    bcl_edge_t        ero_edge;
    logic             last;
  } bcl_item_t;

  // One result word
  typedef struct packed {
    logic pixel_out;
    logic frame_last;
  } bcl_word_t;

  // Expand edge flags to a 9-bit in-frame mask.
  // Bits [8:6] left column, [5:3] center, [2:0] right; in each column bit 0 is the top row.
  function automatic logic [8:0] win_mask(bcl_edge_t e);
    logic [2:0] rows;
    logic [2:0] cols;
    logic [8:0] m;
    int         i;
    int         j;
    rows = {e.bot, 1'b1, e.top};
    cols = {e.left, 1'b1, e.right};
    m    = '0;
    for (j = 0; j < 3; j++) begin
      for (i = 0; i < 3; i++) begin
        m[j*3+i] = cols[j] & rows[i];
      end
    end
    return m;
  endfunction

endpackage

// ----- design/bcl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module bcl_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/bcl_window.sv -----
// Line store plus 3x3 window: read-modify-write of a two-row column word per pixel.
module bcl_window (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     rd_en,
  input  logic [bcl_pkg::COL_W-1:0] rd_addr,
  input  logic                     pix,
  output logic [8:0]               win
);
  import bcl_pkg::*;

  logic             valid_r;
  logic             pix_r;
  logic [COL_W-1:0] addr_r;
  logic             fwd_r;
  logic [LS_W-1:0]  fwd_data_r;
  logic [8:0]       win_r;
  logic [LS_W-1:0]  rdata;
  logic [LS_W-1:0]  word;
  logic [LS_W-1:0]  wdata;
  logic [2:0]       col;

  // Stored word holds {row r, row r-1}; a read gives the two rows above the pixel
  bcl_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (step && valid_r),
    .waddr (addr_r),
    .wdata (wdata),
    .re    (step && rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Take the word being written in the same cycle as our read
  assign word  = fwd_r ? fwd_data_r : rdata;
  assign col   = {pix_r, word};
  assign wdata = {pix_r, word[1]};

  // Advance control and shift the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      fwd_r   <= 1'b0;
      win_r   <= '0;
    end else if (step) begin
      valid_r <= rd_en;
      fwd_r   <= valid_r && (addr_r == rd_addr);
      if (valid_r) begin
        win_r <= {win_r[5:0], col};
      end
    end
  end

  // Hold pixel, address and bypass word
  always_ff @(posedge clk) begin
    if (step) begin
      pix_r      <= pix;
      addr_r     <= rd_addr;
      fwd_data_r <= wdata;
    end
  end

  assign win = win_r;

endmodule

// ----- design/bcl_ctrl.sv -----
// Frame registers, raster position counters and per-item control for the closing block.
module bcl_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcl_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         take,
  input  logic                         in_filler,
  output logic                         go,
  output bcl_pkg::bcl_item_t           item,
  output logic [bcl_pkg::COL_W-1:0]    col_addr
);
  import bcl_pkg::*;

  logic [FW_W-1:0]   frame_width_r,  frame_width_nxt;
  logic [FH_W-1:0]   frame_height_r, frame_height_nxt;
  logic [WARM_W-1:0] warm_r, warm_nxt;
  logic [COL_W-1:0]  ic_r, ic_nxt;
  logic [ROW_W-1:0]  ir_r, ir_nxt;
  logic [COL_W-1:0]  dc_r, dc_nxt;
  logic [ROW_W-1:0]  dr_r, dr_nxt;
  logic [COL_W-1:0]  ec_r, ec_nxt;
  logic [ROW_W-1:0]  er_r, er_nxt;

  logic [WID_W-1:0]  eff_w;
  logic [COL_W-1:0]  w_m1;
  logic [ROW_W-1:0]  eff_h;
  logic [ROW_W-1:0]  h_m1;
  logic [WARM_W-1:0] th_dil;
  logic [WARM_W-1:0] th_out;
  logic              in_frame;
  logic              dil_act;
  logic              out_act;
  logic              last;

  // Clamp frame size
  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = WID_W'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(frame_width_r);
    end
    eff_h = (frame_height_r == '0) ? ROW_W'(1) : ROW_W'(frame_height_r);
  end

  assign w_m1   = COL_W'(eff_w - WID_W'(1));
  assign h_m1   = eff_h - ROW_W'(1);
  assign th_dil = WARM_W'(eff_w) + WARM_W'(1);
  assign th_out = WARM_W'({eff_w, 1'b0}) + WARM_W'(2);

  // Stage activity and item qualification
  assign in_frame = (ir_r < eff_h);
  assign dil_act  = (warm_r >= th_dil);
  assign out_act  = (warm_r >= th_out);
  assign last     = out_act && (er_r == h_m1) && (ec_r == w_m1);
  assign go       = take && !(in_frame && in_filler);
  assign col_addr = ic_r;

  // Control word for this item
  always_comb begin
    item.dil_v          = dil_act;
    item.dil_edge.top   = (dr_r != '0);
    item.dil_edge.bot   = (dr_r < h_m1);
    item.dil_edge.left  = (dc_r != '0);
    item.dil_edge.right = (dc_r != w_m1);
    item.dil_addr       = dc_r;
    item.out_v          = out_act;
    item.ero_edge.top   = (er_r != '0);
    item.ero_edge.bot   = (er_r < h_m1);
    item.ero_edge.left  = (ec_r != '0);
    item.ero_edge.right = (ec_r != w_m1);
    item.last           = last;
  end

  // Next register and counter values
  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    warm_nxt         = warm_r;
    ic_nxt           = ic_r;
    ir_nxt           = ir_r;
    dc_nxt           = dc_r;
    dr_nxt           = dr_r;
    ec_nxt           = ec_r;
    er_nxt           = er_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_wdata[FH_W-1:0];
        default: ;
      endcase
      // Restart the frame
      warm_nxt = '0;
      ic_nxt   = '0;
      ir_nxt   = '0;
      dc_nxt   = '0;
      dr_nxt   = '0;
      ec_nxt   = '0;
      er_nxt   = '0;
    end else if (go) begin
      if (last) begin
        warm_nxt = '0;
        ic_nxt   = '0;
        ir_nxt   = '0;
        dc_nxt   = '0;
        dr_nxt   = '0;
        ec_nxt   = '0;
        er_nxt   = '0;
      end else begin
        if (!out_act) begin
          warm_nxt = warm_r + WARM_W'(1);
        end
        // Input position: column keeps cycling through the flush, row stops at the frame end
        ic_nxt = (ic_r == w_m1) ? '0 : ic_r + COL_W'(1);
        if (in_frame && (ic_r == w_m1)) begin
          ir_nxt = ir_r + ROW_W'(1);
        end
        // Dilation center
        if (dil_act) begin
          dc_nxt = (dc_r == w_m1) ? '0 : dc_r + COL_W'(1);
          if ((dc_r == w_m1) && (dr_r < eff_h)) begin
            dr_nxt = dr_r + ROW_W'(1);
          end
        end
        // Result position
        if (out_act) begin
          ec_nxt = (ec_r == w_m1) ? '0 : ec_r + COL_W'(1);
          if (ec_r == w_m1) begin
            er_nxt = er_r + ROW_W'(1);
          end
        end
      end
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      warm_r         <= '0;
      ic_r           <= '0;
      ir_r           <= '0;
      dc_r           <= '0;
      dr_r           <= '0;
      ec_r           <= '0;
      er_r           <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      warm_r         <= warm_nxt;
      ic_r           <= ic_nxt;
      ir_r           <= ir_nxt;
      dc_r           <= dc_nxt;
      dr_r           <= dr_nxt;
      ec_r           <= ec_nxt;
      er_r           <= er_nxt;
    end
  end

endmodule

// ----- design/bcl_outq.sv -----
// Two-word result stage: output register plus skid register.
module bcl_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bcl_pkg::bcl_word_t push_word,
  input  logic               out_stall,
  output logic               out_valid,
  output bcl_pkg::bcl_word_t out_word,
  output logic               full
);
  import bcl_pkg::*;

  logic      out_valid_r;
  logic      skid_valid_r;
  bcl_word_t out_word_r;
  bcl_word_t skid_word_r;
  logic      out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Move words: skid drains first, else a new word goes straight out
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word_r <= skid_valid_r ? skid_word_r : push_word;
    end else if (push) begin
      skid_word_r <= push_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign full      = skid_valid_r;

endmodule

// ----- design/binary_closing_3x3.sv -----
// Top level of the streaming 3x3 binary closing (dilation then erosion).
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_pixel_in, in_filler
//  out      output     out_valid/out_stall  out_pixel_out, out_frame_last
//  cfg      input      cfg_we               cfg_index, cfg_wdata
//
// One pixel word per clock unless in_stall; a result word passes s1 to s4 and the output
// register after its item, which is 2*frame_width+2 positions after its pixel. Each line
// store RAM takes one read and one write per cycle, with a bypass when consecutive pixels
// hit the same column. Reset clears counters, windows and valid flags; line store RAMs
// are not cleared. The output register and a skid register part the sides; in_stall rises
// only while both hold words, and then the whole pipeline holds.
module binary_closing_3x3 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pixel_in,
  input  logic                          in_filler,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_pixel_out,
  output logic                          out_frame_last,
  input  logic                          cfg_we,
  input  logic [bcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcl_pkg::CFG_W-1:0]     cfg_wdata
);
  import bcl_pkg::*;

  logic             adv;
  logic             go;
  bcl_item_t        item;
  logic [COL_W-1:0] col_addr;
  bcl_item_t        s1_r, s1_nxt;
  bcl_item_t        s2_r;
  bcl_item_t        s3_r;
  bcl_item_t        s4_r;
  logic [8:0]       raw_win;
  logic [8:0]       dil_win;
  logic             dil_pix;
  logic             ero_pix;
  logic             q_full;
  bcl_word_t        res_word;
  bcl_word_t        q_word;

  // Pipeline moves unless the skid holds a word
  assign adv      = !q_full;
  assign in_stall = !adv;

  bcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .take      (in_valid && adv),
    .in_filler (in_filler),
    .go        (go),
    .item      (item),
    .col_addr  (col_addr)
  );

  // Drop control of ignored items
  always_comb begin
    s1_nxt       = item;
    s1_nxt.dil_v = go && item.dil_v;
    s1_nxt.out_v = go && item.out_v;
  end

  // Advance the control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
      s4_r <= '0;
    end else if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
    end
  end

  // Raw pixel line store and window
  bcl_window u_raw (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rd_en   (go),
    .rd_addr (col_addr),
    .pix     (in_pixel_in),
    .win     (raw_win)
  );

  // Dilate: any in-frame neighbor set
  assign dil_pix = |(raw_win & win_mask(s2_r.dil_edge));

  // Dilated pixel line store and window
  bcl_window u_dil (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rd_en   (s2_r.dil_v),
    .rd_addr (s2_r.dil_addr),
    .pix     (dil_pix),
    .win     (dil_win)
  );

  // Erode: every in-frame neighbor set
  assign ero_pix = &(dil_win | ~win_mask(s4_r.ero_edge));

  always_comb begin
    res_word.pixel_out  = ero_pix;
    res_word.frame_last = s4_r.last;
  end

  bcl_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv && s4_r.out_v),
    .push_word (res_word),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (q_word),
    .full      (q_full)
  );

  assign out_pixel_out  = q_word.pixel_out;
  assign out_frame_last = q_word.frame_last;

  // Input stalls only while a result waits at the output
  a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result word pending");

  // Skid fills only when the output word was held
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("skid filled while output was free");

  // After a finished result is pushed, the output holds a valid word in the next cycle
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s4_r.out_v) |=> out_valid)
    else $error("result word lost at the output stage");

endmodule
